### rtl/core/timed_setpoint_scheduler_core_defines.svh
// Assertion macros for the setpoint scheduler core
`ifndef TIMED_SETPOINT_SCHEDULER_CORE_DEFINES_SVH
`define TIMED_SETPOINT_SCHEDULER_CORE_DEFINES_SVH

// implication checked on every clock edge outside reset
`define TSS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define TSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/tss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tss_pkg;

  localparam int unsigned TimeW  = 48;
  localparam int unsigned LevelW = 32;
  localparam int unsigned CountW = 5;

  typedef enum logic [2:0] {
    MODE_ADVANCE  = 3'd0,
    MODE_INS_TIME = 3'd1,
    MODE_INS_LAST = 3'd2,
    MODE_CLEAR    = 3'd3,
    MODE_PREDICT  = 3'd4,
    MODE_PRESET   = 3'd5
  } mode_e;

  localparam logic REG_MIN_LEVEL = 1'b0;
  localparam logic REG_MAX_LEVEL = 1'b1;

  typedef struct packed {
    logic [2:0]               mode;
    logic [TimeW-1:0]         event_time;
    logic signed [LevelW-1:0] target_level;
  } in_item_t;

  typedef struct packed {
    logic signed [LevelW-1:0] output_level;
    logic signed [LevelW-1:0] head_target;
    logic [TimeW-1:0]         next_time;
    logic [CountW-1:0]        pending_count;
    logic                     dropped;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_POP,
    ST_REPORT
  } state_e;

endpackage
`default_nettype wire

### rtl/core/tss_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Front: takes commands and holds them in a two-entry queue.
module tss_front
  import tss_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire in_item_t item_i,
  output logic          full_o,
  output logic          valid_o,
  output in_item_t      item_o,
  input  wire logic     pop_i
);

  in_item_t   buf_q [2];
  logic [1:0] cnt_q;
  logic       rd_q, wr_q;
  logic       push;

  assign full_o  = (cnt_q == 2'd2);
  assign push    = start_i && !full_o;
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = buf_q[rd_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= item_i;
    end
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop_i);
    end
  end

endmodule
`default_nettype wire

### rtl/core/tss_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Back: executes commands on the sorted queue, one entry step a cycle.
module tss_back
  import tss_pkg::*;
#(
  parameter int unsigned QueueDepth = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire in_item_t          item_i,
  output logic                   pop_o,
  input  wire logic signed [LevelW-1:0] min_i,
  input  wire logic signed [LevelW-1:0] max_i,
  output logic                   strobe_o,
  output out_item_t              result_o
);

  localparam int unsigned IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [TimeW-1:0]         times_q  [QueueDepth];
  logic signed [LevelW-1:0] levels_q [QueueDepth];

  state_e                   state_q, state_d;
  logic [CntW-1:0]          count_q, count_d;
  logic [CntW-1:0]          idx_q, idx_d;
  logic signed [LevelW-1:0] cur_q, cur_d;
  logic [TimeW-1:0]         last_q, last_d;
  logic                     lvalid_q, lvalid_d;
  logic                     drop_q, drop_d;
  in_item_t                 cmd_q;
  logic [TimeW-1:0]         ins_time;
  logic                     take;
  logic                     do_shift, do_write, do_pop;
  logic [IdxW-1:0]          wr_idx;
  logic signed [LevelW-1:0] head_clamp;
  logic                     head_due;
  logic                     strobe_d;

  function automatic logic signed [LevelW-1:0] clamp(
    input logic signed [LevelW-1:0] v,
    input logic signed [LevelW-1:0] lo,
    input logic signed [LevelW-1:0] hi
  );
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  assign ins_time   = (cmd_q.mode == MODE_INS_LAST) ? last_q : cmd_q.event_time;
  assign head_clamp = clamp(levels_q[0], min_i, max_i);
  assign head_due   = (count_q != '0) && (times_q[0] <= cmd_q.event_time);
  assign take       = (state_q == ST_IDLE) && valid_i;
  assign pop_o      = take;
  assign wr_idx     = idx_q[IdxW-1:0];

  // control
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    cur_d    = cur_q;
    last_d   = last_q;
    lvalid_d = lvalid_q;
    drop_d   = drop_q;
    do_shift = 1'b0;
    do_write = 1'b0;
    do_pop   = 1'b0;
    strobe_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        drop_d  = 1'b0;
        state_d = ST_REPORT;
        unique case (cmd_q.mode) inside
          MODE_ADVANCE: begin
            if (!(lvalid_q && cmd_q.event_time == last_q)) begin
              last_d   = cmd_q.event_time;
              lvalid_d = 1'b1;
              state_d  = ST_POP;
            end
          end
          MODE_INS_TIME, MODE_INS_LAST: begin
            if (count_q >= CntW'(QueueDepth)) begin
              drop_d = 1'b1;
            end else begin
              idx_d   = count_q;
              state_d = ST_SHIFT;
            end
          end
          MODE_CLEAR:  count_d = '0;
          MODE_PRESET: cur_d = cmd_q.target_level;
          default: ;
        endcase
      end
      ST_SHIFT: begin
        // walk down from the tail, moving later entries up
        if (idx_q != '0 && times_q[wr_idx - IdxW'(1)] > ins_time) begin
          do_shift = 1'b1;
          idx_d    = idx_q - CntW'(1);
        end else begin
          do_write = 1'b1;
          count_d  = count_q + CntW'(1);
          state_d  = ST_REPORT;
        end
      end
      ST_POP: begin
        // one due head per cycle
        if (count_q != '0 && times_q[0] <= last_q) begin
          do_pop  = 1'b1;
          cur_d   = head_clamp;
          count_d = count_q - CntW'(1);
        end else begin
          state_d = ST_REPORT;
        end
      end
      ST_REPORT: begin
        strobe_d = 1'b1;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (take) cmd_q <= item_i;
    for (int i = 0; i < QueueDepth; i++) begin
      if (do_pop) begin
        if (i < QueueDepth - 1) begin
          times_q[i]  <= times_q[i+1];
          levels_q[i] <= levels_q[i+1];
        end
      end else if (do_shift && wr_idx == IdxW'(i)) begin
        times_q[i]  <= times_q[i-1 < 0 ? 0 : i-1];
        levels_q[i] <= levels_q[i-1 < 0 ? 0 : i-1];
      end else if (do_write && wr_idx == IdxW'(i)) begin
        times_q[i]  <= ins_time;
        levels_q[i] <= cmd_q.target_level;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      idx_q    <= '0;
      cur_q    <= '0;
      last_q   <= '0;
      lvalid_q <= 1'b0;
      drop_q   <= 1'b0;
      strobe_o <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      cur_q    <= cur_d;
      last_q   <= last_d;
      lvalid_q <= lvalid_d;
      drop_q   <= drop_d;
      strobe_o <= strobe_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (strobe_d) begin
      result_o.output_level  <= (cmd_q.mode == MODE_PREDICT && head_due) ? head_clamp : cur_q;
      result_o.head_target   <= (count_q != '0) ? levels_q[0] : cur_q;
      result_o.next_time     <= (count_q != '0) ? times_q[0] : '1;
      result_o.pending_count <= CountW'(count_q);
      result_o.dropped       <= drop_q;
    end
  end

endmodule
`default_nettype wire

### rtl/core/timed_setpoint_scheduler_core.sv
`timescale 1ns / 1ps
`default_nettype none
// The back end takes a command from the two-item queue, decodes it in scan and
// registers result and strobe in report. An insert first moves up to QUEUE_DEPTH-1
// later entries in shift, an advance pops due heads in pop; a repeated advance or a
// dropped insert skips both. The single-step back end finishes one item before the
// next, while the command queue lets start be taken as it works.
// Reset clears the queue, current level, last time and limits to full range.
module timed_setpoint_scheduler_core
  import tss_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    item_i,
  output logic             strobe,
  output out_item_t        result_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [LevelW-1:0] cfg_data_i
);

  logic                     q_valid, q_pop;
  in_item_t                 q_item;
  logic signed [LevelW-1:0] min_q, max_q;

  assign cfg_ready_o = 1'b1;

  // limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= {1'b1, {(LevelW-1){1'b0}}};
      max_q <= {1'b0, {(LevelW-1){1'b1}}};
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_MIN_LEVEL) min_q <= cfg_data_i;
      if (cfg_index_i == REG_MAX_LEVEL) max_q <= cfg_data_i;
    end
  end

  tss_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .item_i  (item_i),
    .full_o  (busy),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (q_pop)
  );

  tss_back #(.QueueDepth(QUEUE_DEPTH)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (q_valid),
    .item_i   (q_item),
    .pop_o    (q_pop),
    .min_i    (min_q),
    .max_i    (max_q),
    .strobe_o (strobe),
    .result_o (result_o)
  );

endmodule
`default_nettype wire

### rtl/core/tss_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "timed_setpoint_scheduler_core_defines.svh"
// Port-level checks on the scheduler core.
module tss_checker
  import tss_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      strobe,
  input wire out_item_t result_o
);

  logic rep_empty, rep_drop;

  assign rep_empty = strobe && (result_o.pending_count == '0);
  assign rep_drop  = strobe && result_o.dropped;

  // strobe is a single-cycle pulse per item
  `TSS_ASSERT_NEXT(a_strobe_pulse, clk_i, rst_ni, strobe, !strobe)
  // an empty queue reports all-ones time
  `TSS_ASSERT_IMPL(a_empty_time, clk_i, rst_ni, rep_empty, result_o.next_time == '1)
  // a drop only happens with a full queue, seen as a nonzero pending count
  `TSS_ASSERT_IMPL(a_drop_full, clk_i, rst_ni, rep_drop, result_o.pending_count != '0)

endmodule

bind timed_setpoint_scheduler_core tss_checker u_tss_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .strobe   (strobe),
  .result_o (result_o)
);
`default_nettype wire
